### rtl/core/pdmc_pkg.sv
// Shared types and constants of the profiled drive move controller.
package pdmc_pkg;

   typedef enum logic [1:0] {
      MODE_FORWARD    = 2'd0,
      MODE_BACKWARD   = 2'd1,
      MODE_TURN_LEFT  = 2'd2,
      MODE_TURN_RIGHT = 2'd3
   } move_mode_type;

   typedef struct packed {
      logic [22:0]   target_ticks;
      logic [15:0]   distance_gain;
      logic [15:0]   alignment_gain;
      logic [15:0]   slew_limit;
      logic [11:0]   decel_factor;
      move_mode_type move_mode;
   } cfg_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 23;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_TICKS   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISTANCE_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALIGNMENT_GAIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLEW_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECEL_FACTOR   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOVE_MODE      = 3'd5;

   // Power is unsigned Q8.16.
   localparam logic [23:0] POWER_MAX = 24'd13107200;  // 200.0
   localparam logic [23:0] CREEP_MIN = 24'd327680;    // 5.0
   localparam logic [9:0]  VEL_LIMIT = 10'd1023;

endpackage

### rtl/core/profiled_drive_move_controller.sv
// Profiled drive move controller: top level with handshake and stage control.
//
// Each req item is one sample of the four wheel encoder positions plus a
// start flag that opens a new move. Each sample yields exactly one rsp item
// holding the left and right velocity commands in RPM and the done flag.
// Registers are written through the csr channel, which is always ready. The
// host must write them only while no item is in flight; nothing enforces it.
//
// An accepted item passes the input register and then the result register,
// which drives rsp_valid; a stalled receiver can hold it back. The side
// averages are formed on the way into the input register and the power
// profile on the way into the result register. One item is taken every
// cycle without a stall; running power feeds back inside the second stage.
//
// Reset clears running power and the done latch and loads the default
// gains. When the receiver stalls, the result waits in the output register
// while one more sample may still enter the input register; req_ready falls
// only when both registers hold items.
module profiled_drive_move_controller #(
   parameter int ENCODER_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_start_move,
   input  logic signed [ENCODER_BITS-1:0]        req_left_front_pos,
   input  logic signed [ENCODER_BITS-1:0]        req_left_back_pos,
   input  logic signed [ENCODER_BITS-1:0]        req_right_front_pos,
   input  logic signed [ENCODER_BITS-1:0]        req_right_back_pos,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [10:0]                    rsp_left_velocity,
   output logic signed [10:0]                    rsp_right_velocity,
   output logic                                  rsp_move_done,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pdmc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   pdmc_pkg::cfg_type       cfg;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    advance;
   logic                    load_sample;
   logic                    load_result;
   logic                    start_move_ff;
   logic [ENCODER_BITS-1:0] left_ticks_ff;
   logic [ENCODER_BITS-1:0] right_ticks_ff;
   logic [ENCODER_BITS-1:0] mean_ticks_ff;
   logic [ENCODER_BITS-1:0] diff_ticks_ff;

   assign csr_ready   = 1'b1;
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign load_result = in_valid_ff && advance;
   assign req_ready   = !in_valid_ff || advance;
   assign load_sample = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load_sample) begin
         in_valid_in = 1'b1;
      end else if (load_result) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   pdmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pdmc_sample #(
      .ENCODER_BITS (ENCODER_BITS)
   ) u_sample (
      .clock           (clock),
      .load            (load_sample),
      .start_move      (req_start_move),
      .left_front_pos  (req_left_front_pos),
      .left_back_pos   (req_left_back_pos),
      .right_front_pos (req_right_front_pos),
      .right_back_pos  (req_right_back_pos),
      .start_move_ff   (start_move_ff),
      .left_ticks_ff   (left_ticks_ff),
      .right_ticks_ff  (right_ticks_ff),
      .mean_ticks_ff   (mean_ticks_ff),
      .diff_ticks_ff   (diff_ticks_ff)
   );

   pdmc_power #(
      .ENCODER_BITS (ENCODER_BITS)
   ) u_power (
      .clock             (clock),
      .reset             (reset),
      .load              (load_result),
      .cfg               (cfg),
      .start_move        (start_move_ff),
      .left_ticks        (left_ticks_ff),
      .right_ticks       (right_ticks_ff),
      .mean_ticks        (mean_ticks_ff),
      .diff_ticks        (diff_ticks_ff),
      .left_velocity_ff  (rsp_left_velocity),
      .right_velocity_ff (rsp_right_velocity),
      .move_done_ff      (rsp_move_done)
   );

endmodule

### rtl/core/pdmc_csr.sv
// Configuration registers of the profiled drive move controller.
module pdmc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pdmc_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output pdmc_pkg::cfg_type                     cfg
);

   pdmc_pkg::cfg_type cfg_ff;
   pdmc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            pdmc_pkg::CSR_TARGET_TICKS:   cfg_in.target_ticks   = csr_data[22:0];
            pdmc_pkg::CSR_DISTANCE_GAIN:  cfg_in.distance_gain  = csr_data[15:0];
            pdmc_pkg::CSR_ALIGNMENT_GAIN: cfg_in.alignment_gain = csr_data[15:0];
            pdmc_pkg::CSR_SLEW_LIMIT:     cfg_in.slew_limit     = csr_data[15:0];
            pdmc_pkg::CSR_DECEL_FACTOR:   cfg_in.decel_factor   = csr_data[11:0];
            pdmc_pkg::CSR_MOVE_MODE:
               cfg_in.move_mode = pdmc_pkg::move_mode_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_ticks   <= 23'd0;
         cfg_ff.distance_gain  <= 16'd9830;
         cfg_ff.alignment_gain <= 16'd9830;
         cfg_ff.slew_limit     <= 16'd197;
         cfg_ff.decel_factor   <= 12'd896;
         cfg_ff.move_mode      <= pdmc_pkg::MODE_FORWARD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/pdmc_sample.sv
// Input stage: side averages, their mean and their difference, registered.
module pdmc_sample #(
   parameter int ENCODER_BITS = 24
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           start_move,
   input  logic signed [ENCODER_BITS-1:0] left_front_pos,
   input  logic signed [ENCODER_BITS-1:0] left_back_pos,
   input  logic signed [ENCODER_BITS-1:0] right_front_pos,
   input  logic signed [ENCODER_BITS-1:0] right_back_pos,
   output logic                           start_move_ff,
   output logic [ENCODER_BITS-1:0]        left_ticks_ff,
   output logic [ENCODER_BITS-1:0]        right_ticks_ff,
   output logic [ENCODER_BITS-1:0]        mean_ticks_ff,
   output logic [ENCODER_BITS-1:0]        diff_ticks_ff
);

   localparam int SW = ENCODER_BITS + 1;

   logic signed [SW-1:0]    left_sum;
   logic signed [SW-1:0]    right_sum;
   logic signed [SW-1:0]    left_half;
   logic signed [SW-1:0]    right_half;
   logic [ENCODER_BITS-1:0] left_ticks_in;
   logic [ENCODER_BITS-1:0] right_ticks_in;
   logic [SW-1:0]           mean_sum;
   logic signed [SW-1:0]    diff_signed;
   logic [ENCODER_BITS-1:0] diff_ticks_in;

   always_comb begin
      left_sum  = SW'(left_front_pos) + SW'(left_back_pos);
      right_sum = SW'(right_front_pos) + SW'(right_back_pos);
      // Halving rounds toward zero, so a negative sum is bumped by one first.
      left_half  = (left_sum + $signed(SW'(left_sum[SW-1]))) >>> 1;
      right_half = (right_sum + $signed(SW'(right_sum[SW-1]))) >>> 1;
      left_ticks_in  = left_half[SW-1] ? ENCODER_BITS'(-left_half)
                                       : left_half[ENCODER_BITS-1:0];
      right_ticks_in = right_half[SW-1] ? ENCODER_BITS'(-right_half)
                                        : right_half[ENCODER_BITS-1:0];
      mean_sum    = {1'b0, left_ticks_in} + {1'b0, right_ticks_in};
      diff_signed = $signed({1'b0, left_ticks_in}) - $signed({1'b0, right_ticks_in});
      diff_ticks_in = diff_signed[SW-1] ? ENCODER_BITS'(-diff_signed)
                                        : diff_signed[ENCODER_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         start_move_ff  <= start_move;
         left_ticks_ff  <= left_ticks_in;
         right_ticks_ff <= right_ticks_in;
         mean_ticks_ff  <= mean_sum[SW-1:1];
         diff_ticks_ff  <= diff_ticks_in;
      end
   end

endmodule

### rtl/core/pdmc_power.sv
// Power profile stage: speed step, deceleration, alignment trim and result register.
module pdmc_power #(
   parameter int ENCODER_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  pdmc_pkg::cfg_type       cfg,
   input  logic                    start_move,
   input  logic [ENCODER_BITS-1:0] left_ticks,
   input  logic [ENCODER_BITS-1:0] right_ticks,
   input  logic [ENCODER_BITS-1:0] mean_ticks,
   input  logic [ENCODER_BITS-1:0] diff_ticks,
   output logic signed [10:0]      left_velocity_ff,
   output logic signed [10:0]      right_velocity_ff,
   output logic                    move_done_ff
);

   localparam int CW = (ENCODER_BITS > 23) ? ENCODER_BITS : 23;
   localparam int AW = ENCODER_BITS + 16;
   localparam int VW = ENCODER_BITS + 18;

   logic [23:0]          running_power_ff;
   logic [23:0]          running_power_in;
   logic                 done_latch_ff;
   logic                 done_latch_in;
   logic signed [10:0]   left_velocity_in;
   logic signed [10:0]   right_velocity_in;

   logic [23:0]          power;
   logic                 done_now;
   logic [22:0]          rem;
   logic [38:0]          step_prod;
   logic [15:0]          step_mag;
   logic [35:0]          decel_prod;
   logic                 decel_hit;
   logic signed [25:0]   base;
   logic [AW-1:0]        align;
   logic signed [VW-1:0] left_q;
   logic signed [VW-1:0] right_q;

   function automatic logic [10:0] to_rpm(input logic signed [VW-1:0] q);
      logic [VW-1:0] mag_full;
      logic [9:0]    mag;
      mag_full = q[VW-1] ? VW'(-q) : VW'(q);
      if (mag_full[VW-1:16] > (VW-16)'(pdmc_pkg::VEL_LIMIT)) begin
         mag = pdmc_pkg::VEL_LIMIT;
      end else begin
         mag = mag_full[25:16];
      end
      return q[VW-1] ? 11'(-{1'b0, mag}) : {1'b0, mag};
   endfunction

   always_comb begin
      power    = start_move ? 24'd0 : running_power_ff;
      done_now = (!start_move && done_latch_ff) || (CW'(mean_ticks) >= CW'(cfg.target_ticks));
      rem      = cfg.target_ticks - 23'(mean_ticks);

      step_prod = rem * cfg.distance_gain;
      step_mag  = (step_prod > {23'd0, cfg.slew_limit}) ? cfg.slew_limit : step_prod[15:0];

      // Power in Q.16 times factor in Q.8 set against the remaining ticks in Q.24.
      decel_prod = power * cfg.decel_factor;
      decel_hit  = {11'd0, decel_prod} > {rem, 24'd0};

      if (!decel_hit) begin
         base = $signed({2'b00, power}) + $signed({10'd0, step_mag});
      end else if (power < pdmc_pkg::CREEP_MIN) begin
         base = $signed({2'b00, pdmc_pkg::CREEP_MIN});
      end else begin
         base = $signed({2'b00, power}) - $signed({10'd0, step_mag});
      end

      align   = diff_ticks * cfg.alignment_gain;
      left_q  = VW'(base);
      right_q = VW'(base);
      if (left_ticks > right_ticks) begin
         left_q = VW'(base) - $signed(VW'(align));
      end else if (right_ticks > left_ticks) begin
         right_q = VW'(base) - $signed(VW'(align));
      end

      case (cfg.move_mode)
         pdmc_pkg::MODE_BACKWARD: begin
            left_q  = -left_q;
            right_q = -right_q;
         end
         pdmc_pkg::MODE_TURN_LEFT:  left_q  = -left_q;
         pdmc_pkg::MODE_TURN_RIGHT: right_q = -right_q;
         default: ;
      endcase

      if (done_now) begin
         left_velocity_in  = 11'sd0;
         right_velocity_in = 11'sd0;
         running_power_in  = power;
      end else begin
         left_velocity_in  = $signed(to_rpm(left_q));
         right_velocity_in = $signed(to_rpm(right_q));
         if (base > $signed({2'b00, pdmc_pkg::POWER_MAX})) begin
            running_power_in = pdmc_pkg::POWER_MAX;
         end else if (base[25]) begin
            running_power_in = 24'd0;
         end else begin
            running_power_in = base[23:0];
         end
      end
      done_latch_in = done_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_power_ff <= 24'd0;
         done_latch_ff    <= 1'b0;
      end else if (load) begin
         running_power_ff <= running_power_in;
         done_latch_ff    <= done_latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_velocity_ff  <= left_velocity_in;
         right_velocity_ff <= right_velocity_in;
         move_done_ff      <= done_latch_in;
      end
   end

endmodule

### sim/drive_command_checker.sv
`timescale 1ns / 100ps
// Checker for the move controller: predicts each drive command and compares every rsp item.
module drive_command_checker #(
   parameter int ENCODER_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_start_move,
   input  logic signed [ENCODER_BITS-1:0]       req_left_front_pos,
   input  logic signed [ENCODER_BITS-1:0]       req_left_back_pos,
   input  logic signed [ENCODER_BITS-1:0]       req_right_front_pos,
   input  logic signed [ENCODER_BITS-1:0]       req_right_back_pos,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [10:0]                   rsp_left_velocity,
   input  logic signed [10:0]                   rsp_right_velocity,
   input  logic                                 rsp_move_done,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pdmc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                   failures,
   output int                                   pending
);

   typedef struct packed {
      logic signed [10:0] left_velocity;
      logic signed [10:0] right_velocity;
      logic               move_done;
   } drive_command_type;

   drive_command_type expected_commands[$];
   drive_command_type oldest;
   pdmc_pkg::cfg_type regs;
   logic [23:0]       power_q16;
   logic              move_finished;

   function automatic logic signed [10:0] rpm_command(input longint q);
      longint mag;
      mag = (q < 0 ? -q : q) >> 16;
      if (mag > longint'(pdmc_pkg::VEL_LIMIT)) mag = longint'(pdmc_pkg::VEL_LIMIT);
      return 11'(q < 0 ? -mag : mag);
   endfunction

   function automatic drive_command_type command_for_sample(
      input logic start,
      input logic signed [ENCODER_BITS-1:0] lf,
      input logic signed [ENCODER_BITS-1:0] lb,
      input logic signed [ENCODER_BITS-1:0] rf,
      input logic signed [ENCODER_BITS-1:0] rb
   );
      longint left_ticks, right_ticks, mean_ticks, remaining;
      longint power, step, base, trim, left_cmd, right_cmd;
      drive_command_type cmd;
      cmd = '0;
      if (start) begin
         power_q16 = '0;
         move_finished = 1'b0;
      end
      // Side averages truncate toward zero before the magnitude is taken.
      left_ticks = (longint'(lf) + longint'(lb)) / 2;
      right_ticks = (longint'(rf) + longint'(rb)) / 2;
      if (left_ticks < 0) left_ticks = -left_ticks;
      if (right_ticks < 0) right_ticks = -right_ticks;
      mean_ticks = (left_ticks + right_ticks) / 2;
      if (move_finished || mean_ticks >= longint'(regs.target_ticks)) begin
         move_finished = 1'b1;
         cmd.move_done = 1'b1;
         return cmd;
      end
      power = longint'(power_q16);
      remaining = longint'(regs.target_ticks) - mean_ticks;
      step = remaining * longint'(regs.distance_gain);
      if (step > longint'(regs.slew_limit)) step = longint'(regs.slew_limit);
      // Power in Q.16 times the factor in Q.8 is weighed against the remaining ticks in Q.24.
      if (power * longint'(regs.decel_factor) > (remaining <<< 24)) begin
         step = -step;
         if (power < longint'(pdmc_pkg::CREEP_MIN)) begin
            step = longint'(pdmc_pkg::CREEP_MIN) - power;
         end
      end
      base = power + step;
      trim = (left_ticks > right_ticks) ? left_ticks - right_ticks : right_ticks - left_ticks;
      trim = trim * longint'(regs.alignment_gain);
      left_cmd = (left_ticks > right_ticks) ? base - trim : base;
      right_cmd = (right_ticks > left_ticks) ? base - trim : base;
      case (regs.move_mode)
         pdmc_pkg::MODE_BACKWARD: begin
            left_cmd = -left_cmd;
            right_cmd = -right_cmd;
         end
         pdmc_pkg::MODE_TURN_LEFT: left_cmd = -left_cmd;
         pdmc_pkg::MODE_TURN_RIGHT: right_cmd = -right_cmd;
         default: ;
      endcase
      cmd.left_velocity = rpm_command(left_cmd);
      cmd.right_velocity = rpm_command(right_cmd);
      if (base > longint'(pdmc_pkg::POWER_MAX)) base = longint'(pdmc_pkg::POWER_MAX);
      else if (base < 0) base = 0;
      power_q16 = base[23:0];
      return cmd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         regs.target_ticks = '0;
         regs.distance_gain = 16'd9830;
         regs.alignment_gain = 16'd9830;
         regs.slew_limit = 16'd197;
         regs.decel_factor = 12'd896;
         regs.move_mode = pdmc_pkg::MODE_FORWARD;
         power_q16 = '0;
         move_finished = 1'b0;
         expected_commands.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pdmc_pkg::CSR_TARGET_TICKS: regs.target_ticks = csr_data[22:0];
               pdmc_pkg::CSR_DISTANCE_GAIN: regs.distance_gain = csr_data[15:0];
               pdmc_pkg::CSR_ALIGNMENT_GAIN: regs.alignment_gain = csr_data[15:0];
               pdmc_pkg::CSR_SLEW_LIMIT: regs.slew_limit = csr_data[15:0];
               pdmc_pkg::CSR_DECEL_FACTOR: regs.decel_factor = csr_data[11:0];
               pdmc_pkg::CSR_MOVE_MODE:
                  regs.move_mode = pdmc_pkg::move_mode_type'(csr_data[1:0]);
               default: ;
            endcase
         end
         // The result is checked before this edge's sample is predicted, so that an
         // unexpected item cannot consume a fresh expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               failures++;
               $error("rsp item with no command expected");
            end else begin
               oldest = expected_commands.pop_front();
               if (rsp_left_velocity !== oldest.left_velocity) begin
                  failures++;
                  $error("left_velocity: expected %0d, actual %0d",
                         oldest.left_velocity, rsp_left_velocity);
               end
               if (rsp_right_velocity !== oldest.right_velocity) begin
                  failures++;
                  $error("right_velocity: expected %0d, actual %0d",
                         oldest.right_velocity, rsp_right_velocity);
               end
               if (rsp_move_done !== oldest.move_done) begin
                  failures++;
                  $error("move_done: expected %0d, actual %0d",
                         oldest.move_done, rsp_move_done);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_commands.push_back(command_for_sample(req_start_move,
               req_left_front_pos, req_left_back_pos, req_right_front_pos,
               req_right_back_pos));
         end
      end
      pending = expected_commands.size();
   end

endmodule

### sim/tb_profiled_drive_move_controller.sv
`timescale 1ns / 100ps
// Testbench top: drives encoder samples and register writes into the move controller.
module tb_profiled_drive_move_controller;

   localparam int     ENCODER_BITS  = 24;
   localparam longint POS_MAX       = 8388607;
   localparam longint POS_MIN       = -8388608;
   localparam int     RANDOM_ITEMS  = 1200;
   localparam int     CYCLE_LIMIT   = 800000;
   localparam logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW  = 3'd6;
   localparam logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HIGH = 3'd7;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_start_move;
   logic signed [ENCODER_BITS-1:0]       req_left_front_pos;
   logic signed [ENCODER_BITS-1:0]       req_left_back_pos;
   logic signed [ENCODER_BITS-1:0]       req_right_front_pos;
   logic signed [ENCODER_BITS-1:0]       req_right_back_pos;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [10:0]                   rsp_left_velocity;
   logic signed [10:0]                   rsp_right_velocity;
   logic                                 rsp_move_done;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [pdmc_pkg::CSR_DATA_WIDTH-1:0]  csr_data;
   int                                   failures;
   int                                   pending;

   int                cycles = 0;
   int                samples_sent = 0;
   bit                send_idle;
   bit                take_idle;
   pdmc_pkg::cfg_type active;

   profiled_drive_move_controller #(.ENCODER_BITS(ENCODER_BITS)) i_dut (.*);

   drive_command_checker #(.ENCODER_BITS(ENCODER_BITS)) i_checker (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
      return int'($urandom_range(4, 40));
   endfunction

   // The receiver stalls only in phases that ask for it, so some stretches run flat out.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && take_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (idle_length()) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_sample(input logic start, input longint lf, input longint lb,
                              input longint rf, input longint rb);
      if (send_idle && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_move <= start;
      req_left_front_pos <= lf[ENCODER_BITS-1:0];
      req_left_back_pos <= lb[ENCODER_BITS-1:0];
      req_right_front_pos <= rf[ENCODER_BITS-1:0];
      req_right_back_pos <= rb[ENCODER_BITS-1:0];
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic put_register(input logic [pdmc_pkg::CSR_INDEX_WIDTH-1:0] index,
                               input logic [pdmc_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Registers change only once the controller has handed back every command.
   task automatic program_config(input pdmc_pkg::cfg_type c, input bit stray);
      drain();
      if (stray) put_register(CSR_UNUSED_LOW, pdmc_pkg::CSR_DATA_WIDTH'($urandom));
      put_register(pdmc_pkg::CSR_TARGET_TICKS, c.target_ticks);
      put_register(pdmc_pkg::CSR_DISTANCE_GAIN, pdmc_pkg::CSR_DATA_WIDTH'(c.distance_gain));
      put_register(pdmc_pkg::CSR_ALIGNMENT_GAIN, pdmc_pkg::CSR_DATA_WIDTH'(c.alignment_gain));
      put_register(pdmc_pkg::CSR_SLEW_LIMIT, pdmc_pkg::CSR_DATA_WIDTH'(c.slew_limit));
      put_register(pdmc_pkg::CSR_DECEL_FACTOR, pdmc_pkg::CSR_DATA_WIDTH'(c.decel_factor));
      put_register(pdmc_pkg::CSR_MOVE_MODE, pdmc_pkg::CSR_DATA_WIDTH'(c.move_mode));
      if (stray) put_register(CSR_UNUSED_HIGH, pdmc_pkg::CSR_DATA_WIDTH'($urandom));
      csr_valid <= 1'b0;
      active = c;
   endtask

   function automatic pdmc_pkg::cfg_type make_settings(
      input int unsigned target, input int unsigned dgain,
      input int unsigned again, input int unsigned slew,
      input int unsigned decel, input pdmc_pkg::move_mode_type mode);
      pdmc_pkg::cfg_type c;
      c.target_ticks = 23'(target);
      c.distance_gain = 16'(dgain);
      c.alignment_gain = 16'(again);
      c.slew_limit = 16'(slew);
      c.decel_factor = 12'(decel);
      c.move_mode = mode;
      return c;
   endfunction

   function automatic int unsigned pick_value(input int unsigned hi, input int unsigned usual);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return hi;
         2: return usual;
         3, 4: return $urandom_range(usual, hi);
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   function automatic pdmc_pkg::cfg_type random_settings();
      int unsigned target;
      case ($urandom_range(0, 9))
         0: target = 0;
         1: target = 32'(POS_MAX);
         2, 3, 4: target = $urandom_range(1, 300);
         5, 6, 7: target = $urandom_range(300, 6000);
         default: target = $urandom_range(6000, 200000);
      endcase
      return make_settings(target, pick_value(65535, 9830), pick_value(65535, 9830),
                           pick_value(65535, 197), pick_value(4095, 896),
                           pdmc_pkg::move_mode_type'($urandom_range(0, 3)));
   endfunction

   function automatic longint wheel(input longint travel, input longint direction);
      longint mag;
      mag = travel + longint'($urandom_range(0, 4)) - 2;
      if (mag < 0) mag = 0;
      if (mag > POS_MAX) mag = POS_MAX;
      return direction * mag;
   endfunction

   function automatic longint noise_position();
      logic signed [ENCODER_BITS-1:0] raw;
      raw = ENCODER_BITS'($urandom);
      case ($urandom_range(0, 7))
         0: return POS_MAX;
         1: return POS_MIN;
         2: return longint'(raw) / 4096;
         default: return longint'(raw);
      endcase
   endfunction

   // One move: a first sample at rest, mostly flagged as a start, then wheels creeping
   // out toward the target and a few samples past it.
   task automatic run_move(input longint stride);
      longint travel, skew, left_dir, right_dir;
      int     tail, count;
      left_dir = 1;
      right_dir = 1;
      case (active.move_mode)
         pdmc_pkg::MODE_BACKWARD: begin
            left_dir = -1;
            right_dir = -1;
         end
         pdmc_pkg::MODE_TURN_LEFT: left_dir = -1;
         pdmc_pkg::MODE_TURN_RIGHT: right_dir = -1;
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) left_dir = -left_dir;
      travel = 0;
      count = 0;
      tail = int'($urandom_range(1, 4));
      send_sample(logic'($urandom_range(0, 9) != 0), wheel(0, left_dir), wheel(0, left_dir),
                  wheel(0, right_dir), wheel(0, right_dir));
      while (tail > 0 && count < 300) begin
         travel += longint'($urandom_range(0, 32'(stride)));
         if (travel >= longint'(active.target_ticks)) tail--;
         if ($urandom_range(0, 19) == 0) skew = longint'($urandom_range(0, 6000)) - 3000;
         else skew = longint'($urandom_range(0, 32'(stride / 4 + 4))) - (stride / 8 + 2);
         send_sample(1'b0, wheel(travel, left_dir), wheel(travel, left_dir),
                     wheel(travel + skew, right_dir), wheel(travel + skew, right_dir));
         count++;
      end
   endtask

   initial begin
      int phase;
      int random_goal;
      int phase_goal;
      pdmc_pkg::cfg_type c;

      reset = 1'b1;
      req_valid = 1'b0;
      req_start_move = 1'b0;
      req_left_front_pos = '0;
      req_left_back_pos = '0;
      req_right_front_pos = '0;
      req_right_back_pos = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle = 1'b0;
      take_idle = 1'b0;
      active = make_settings(0, 9830, 9830, 197, 896, pdmc_pkg::MODE_FORWARD);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset target of zero the first sample already ends the move, and the
      // done flag then holds without a start.
      send_sample(1'b1, 0, 0, 0, 0);
      send_sample(1'b0, 100, 100, 100, 100);

      program_config(make_settings(32'(POS_MAX), 65535, 65535, 65535, 4095,
                                   pdmc_pkg::MODE_TURN_LEFT), 1'b1);
      send_sample(1'b1, 0, 0, 0, 0);
      send_sample(1'b0, 5000, 5000, 0, 0);
      send_sample(1'b0, 0, 0, 7000, 7001);
      send_sample(1'b0, -3, 0, POS_MAX, POS_MIN);
      send_sample(1'b0, -5, -6, 9, 8);
      send_sample(1'b0, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
      send_sample(1'b0, 1, 1, 1, 1);
      send_sample(1'b1, POS_MIN, POS_MIN, POS_MIN, POS_MIN);

      // A short target with a steep braking factor: power climbs, reverses, and then
      // hovers on the creep floor.
      program_config(make_settings(100, 65535, 0, 65535, 4095, pdmc_pkg::MODE_BACKWARD), 1'b0);
      send_sample(1'b1, 0, 0, 0, 0);
      repeat (6) send_sample(1'b0, 0, 0, 0, 0);
      repeat (6) send_sample(1'b0, 98, 98, 99, 99);

      // No slew and no gain: power is carried over from the last move and only creep acts.
      program_config(make_settings(50, 0, 9830, 0, 4095, pdmc_pkg::MODE_TURN_RIGHT), 1'b1);
      repeat (2) send_sample(1'b0, 48, 48, 45, 45);
      send_sample(1'b0, 3, -3, 7, -7);

      random_goal = samples_sent + RANDOM_ITEMS;
      phase = 0;
      while (samples_sent < random_goal) begin
         if (phase == 1) begin
            // No braking and full slew, so power runs up into its ceiling.
            c = make_settings(32'(POS_MAX), 65535, $urandom_range(0, 65535), 65535, 0,
                              pdmc_pkg::move_mode_type'($urandom_range(0, 3)));
         end else begin
            c = random_settings();
         end
         program_config(c, $urandom_range(0, 3) == 0);
         send_idle = $urandom_range(0, 3) != 0;
         take_idle = $urandom_range(0, 3) != 0;
         phase_goal = samples_sent + int'($urandom_range(80, 200));
         if (phase == 1) begin
            run_move(20);
         end
         while (samples_sent < phase_goal && samples_sent < random_goal) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 6))
                  send_sample(logic'($urandom_range(0, 3) == 0), noise_position(),
                              noise_position(), noise_position(), noise_position());
            end else begin
               run_move(longint'(active.target_ticks) / 12 + 2);
            end
         end
         phase++;
      end

      drain();
      repeat (6) @(negedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/pdmc_pkg.sv
rtl/core/pdmc_csr.sv
rtl/core/pdmc_sample.sv
rtl/core/pdmc_power.sv
rtl/core/profiled_drive_move_controller.sv
sim/drive_command_checker.sv
sim/tb_profiled_drive_move_controller.sv
